[sv/fpwbs_pkg.sv]
// Shared types, constants and header byte function for the WAV byte stream unit.
package fpwbs_pkg;

  localparam logic CMD_HEADER = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic REG_RATE  = 1'b0;
  localparam logic REG_COUNT = 1'b1;

  localparam int AddrWidth = 3;

  localparam logic [31:0] RATE_RESET  = 32'd16000;
  localparam logic [30:0] COUNT_RESET = 31'd0;

  localparam logic [5:0] HDR_LAST_IDX = 6'd43;
  localparam logic [5:0] SMP_LAST_IDX = 6'd1;

  localparam logic [31:0] W_RIFF    = 32'h4646_4952;
  localparam logic [31:0] W_WAVE    = 32'h4556_4157;
  localparam logic [31:0] W_FMT     = 32'h2074_6d66;
  localparam logic [31:0] W_FMT_LEN = 32'd16;
  localparam logic [31:0] W_PCM_MONO = 32'h0001_0001;
  localparam logic [31:0] W_ALIGN_BITS = 32'h0010_0002;
  localparam logic [31:0] W_DATA    = 32'h6174_6164;
  localparam logic [31:0] RIFF_EXTRA = 32'd36;

  localparam logic [14:0] SCALE_POS = 15'd32767;
  localparam logic [15:0] SCALE_NEG = 16'd32768;
  localparam logic [15:0] SAMPLE_MAX = 16'h7fff;
  localparam logic [15:0] SAMPLE_MIN = 16'h8000;
  localparam logic [7:0]  EXP_ONE    = 8'd127;
  localparam logic [7:0]  EXP_MAX    = 8'd255;
  localparam logic [7:0]  SHIFT_HI   = 8'd135;
  localparam logic [7:0]  SHIFT_LO   = 8'd136;
  localparam logic [7:0]  SHIFT_ZERO = 8'd25;

  typedef struct packed {
    logic        cmd;
    logic [31:0] sample_bits;
  } req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } rsp_t;

  function automatic logic [7:0] header_byte(input logic [5:0] idx,
                                             input logic [31:0] rate,
                                             input logic [30:0] count);
    logic [31:0] dlen;
    logic [31:0] w;
    dlen = {count, 1'b0};
    case (idx[5:2])
      4'd0:    w = W_RIFF;
      4'd1:    w = dlen + RIFF_EXTRA;
      4'd2:    w = W_WAVE;
      4'd3:    w = W_FMT;
      4'd4:    w = W_FMT_LEN;
      4'd5:    w = W_PCM_MONO;
      4'd6:    w = rate;
      4'd7:    w = {rate[30:0], 1'b0};
      4'd8:    w = W_ALIGN_BITS;
      4'd9:    w = W_DATA;
      4'd10:   w = dlen;
      default: w = '0;
    endcase
    return w[{idx[1:0], 3'b000} +: 8];
  endfunction

endpackage

[sv/float_pcm_to_wav_byte_stream_unit.sv]
// Top level: float sample to 16-bit PCM conversion pipeline and WAV byte serializer.
// Usage:
//   req channel (req_valid/req_stall/req) carries one command per transaction:
//   cmd 0 emits the 44-byte RIFF/WAVE header, cmd 1 converts sample_bits
//   (IEEE single) to a 16-bit PCM sample and emits it as two bytes, low first.
//   rsp channel (rsp_valid/rsp_stall/rsp) carries one byte per transaction,
//   with last set on the final byte of each command.
//   Header fields come from the sample_rate (byte 0) and sample_count
//   (byte 4) registers on the APB port; write them only while idle.
//   A command's bytes reach the output register after the decode, multiply and
//   round stages and the serializer. Throughput: one byte per cycle unless rsp
//   stalls, set by the single output register; a sample gives 2 bytes, a header 44.
//   The conversion runs as three register stages (decode, multiply,
//   round and shift) feeding the serializer.
//   Reset clears every stage and the output register and restores
//   sample_rate to 16000 and sample_count to 0.
//   A stall on rsp holds the output byte; the pipeline keeps filling until
//   every stage is full, then req_stall rises. Nothing is lost or repeated.
module float_pcm_to_wav_byte_stream_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  fpwbs_pkg::req_t               req,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output fpwbs_pkg::rsp_t               rsp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fpwbs_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import fpwbs_pkg::*;

  typedef enum logic [1:0] {K_ZERO, K_POS_FULL, K_NEG_FULL, K_NORMAL} kind_t;

  logic [31:0] sample_rate;
  logic [30:0] sample_count;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_rate  <= RATE_RESET;
      sample_count <= COUNT_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_RATE:  sample_rate  <= pwdata;
        REG_COUNT: sample_count <= pwdata[30:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_RATE:  prdata = sample_rate;
      REG_COUNT: prdata = {1'b0, sample_count};
      default:   prdata = '0;
    endcase
  end

  // stage 1: decode
  logic        a_valid, a_cmd, a_sign;
  kind_t       a_kind;
  logic [23:0] a_man;
  logic [7:0]  a_exp;
  // stage 2: multiply
  logic        b_valid, b_cmd, b_sign;
  kind_t       b_kind;
  logic [38:0] b_prod;
  logic [7:0]  b_exp;
  // stage 3: rounded sample
  logic        c_valid, c_cmd;
  logic [15:0] c_sample;
  // serializer
  logic        busy, s_cmd;
  logic [15:0] s_sample;
  logic [5:0]  idx;

  logic a_ready, b_ready, c_ready, out_free, s_take, s_done;
  logic [7:0] in_exp;
  kind_t in_kind;

  assign out_free = !rsp_valid || !rsp_stall;
  assign s_done   = busy && out_free && (idx == (s_cmd ? SMP_LAST_IDX : HDR_LAST_IDX));
  assign s_take   = !busy || s_done;
  assign c_ready  = !c_valid || s_take;
  assign b_ready  = !b_valid || c_ready;
  assign a_ready  = !a_valid || b_ready;
  assign req_stall = !a_ready;

  assign in_exp = req.sample_bits[30:23];
  always_comb begin
    if (in_exp == EXP_MAX && req.sample_bits[22:0] != '0) begin
      in_kind = K_ZERO;
    end else if (in_exp >= EXP_ONE) begin
      in_kind = req.sample_bits[31] ? K_NEG_FULL : K_POS_FULL;
    end else if (in_exp == '0) begin
      in_kind = K_ZERO;
    end else begin
      in_kind = K_NORMAL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= req_valid;
    end
    if (a_ready) begin
      a_cmd  <= req.cmd;
      a_sign <= req.sample_bits[31];
      a_kind <= in_kind;
      a_man  <= {1'b1, req.sample_bits[22:0]};
      a_exp  <= in_exp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_ready) begin
      b_valid <= a_valid;
    end
    if (b_ready) begin
      b_cmd  <= a_cmd;
      b_sign <= a_sign;
      b_kind <= a_kind;
      b_exp  <= a_exp;
      b_prod <= 39'(a_man) * 39'(a_sign ? SCALE_NEG : {1'b0, SCALE_POS});
    end
  end

  logic        hi, rnd_up;
  logic [23:0] keep;
  logic [24:0] rounded, shifted;
  logic [7:0]  sh;
  logic [15:0] mag, conv;

  always_comb begin
    hi = b_prod[38];
    if (hi) begin
      keep   = b_prod[38:15];
      rnd_up = b_prod[14] && ((|b_prod[13:0]) || b_prod[15]);
      sh     = SHIFT_HI - b_exp;
    end else begin
      keep   = b_prod[37:14];
      rnd_up = b_prod[13] && ((|b_prod[12:0]) || b_prod[14]);
      sh     = SHIFT_LO - b_exp;
    end
    rounded = {1'b0, keep} + {24'd0, rnd_up};
    shifted = (sh >= SHIFT_ZERO) ? '0 : (rounded >> sh[4:0]);
    mag     = shifted[15:0];
    case (b_kind)
      K_ZERO:     conv = '0;
      K_POS_FULL: conv = SAMPLE_MAX;
      K_NEG_FULL: conv = SAMPLE_MIN;
      K_NORMAL:   conv = b_sign ? (16'd0 - mag) : mag;
      default:    conv = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (c_ready) begin
      c_valid <= b_valid;
    end
    if (c_ready) begin
      c_cmd    <= b_cmd;
      c_sample <= conv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      rsp_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (out_free) begin
        rsp_valid <= busy;
      end
      if (busy && out_free) begin
        rsp.last     <= s_done;
        rsp.out_byte <= (s_cmd == CMD_HEADER) ? header_byte(idx, sample_rate, sample_count)
                      : (idx[0] ? s_sample[15:8] : s_sample[7:0]);
      end
      if (s_take) begin
        idx <= '0;
      end else if (busy && out_free) begin
        idx <= idx + 6'd1;
      end
      if (s_take) begin
        busy     <= c_valid;
        s_cmd    <= c_cmd;
        s_sample <= c_sample;
      end
    end
  end

endmodule

[sv/fpwbs_checker.sv]
// Port-level assertions for the WAV byte stream unit, bound to the top level.
module fpwbs_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            req_valid,
  input logic                            req_stall,
  input fpwbs_pkg::req_t                 req,
  input logic                            rsp_valid,
  input logic                            rsp_stall,
  input fpwbs_pkg::rsp_t                 rsp,
  input logic                            psel,
  input logic                            penable,
  input logic                            pwrite,
  input logic [fpwbs_pkg::AddrWidth-1:0] paddr,
  input logic [31:0]                     pwdata,
  input logic [31:0]                     prdata,
  input logic                            pready
);
  import fpwbs_pkg::*;

  a_rst_idle: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("output valid after reset");

  a_rst_ready: assert property (@(posedge clk) rst |=> !req_stall)
    else $error("input stalled after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled output changed");

  a_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && pready && paddr[2] == REG_RATE
    |=> paddr[2] != REG_RATE || prdata == $past(pwdata))
    else $error("rate register readback mismatch");

endmodule

bind float_pcm_to_wav_byte_stream_unit fpwbs_checker u_fpwbs_checker (.*);

[verif/float_pcm_to_wav_byte_stream_unit_tb.sv]
// Self-checking testbench for the WAV byte stream unit: random commands, registers and flow control.
module float_pcm_to_wav_byte_stream_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fpwbs_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [AddrWidth-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  req_t pending_cmds[$];
  rsp_t expected_bytes[$];
  logic [31:0] rate_reg;
  logic [30:0] count_reg;
  int errors = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;

  float_pcm_to_wav_byte_stream_unit uut (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [15:0] pcm_of(logic [31:0] bits);
    logic [7:0] e;
    logic [23:0] m;
    longint unsigned prod;
    longint unsigned keep;
    longint unsigned rem;
    longint unsigned half;
    int drop;
    int sh;
    logic [15:0] mag;
    e = bits[30:23];
    m = {1'b1, bits[22:0]};
    if (e == 8'd255 && bits[22:0] != '0) return 16'h0000;
    if (e >= 8'd127) return bits[31] ? 16'h8000 : 16'h7fff;
    if (e == 8'd0) return 16'h0000;
    if (bits[31]) begin
      sh = 135 - int'(e);
      mag = 16'(m >> sh);
      return 16'd0 - mag;
    end
    prod = 64'(m) * 64'd32767;
    drop = 0;
    while ((prod >> drop) >= (64'd1 << 24)) drop++;
    keep = prod >> drop;
    rem = prod - (keep << drop);
    half = 64'd1 << (drop - 1);
    if (rem > half || (rem == half && keep[0])) keep++;
    sh = 150 - int'(e) - drop;
    mag = 16'(keep >> sh);
    return mag;
  endfunction

  function automatic logic [7:0] wav_hdr_byte(int k);
    logic [31:0] dlen;
    logic [31:0] w;
    dlen = {count_reg, 1'b0};
    case (k / 4)
      0: w = "FFIR";
      1: w = dlen + 32'd36;
      2: w = "EVAW";
      3: w = " tmf";
      4: w = 32'd16;
      5: w = 32'h0001_0001;
      6: w = rate_reg;
      7: w = rate_reg * 32'd2;
      8: w = 32'h0010_0002;
      9: w = "atad";
      default: w = dlen;
    endcase
    return w[8 * (k % 4) +: 8];
  endfunction

  task automatic predict_bytes(req_t c);
    logic [15:0] s;
    if (c.cmd == CMD_HEADER) begin
      for (int k = 0; k < 44; k++) expected_bytes.push_back('{wav_hdr_byte(k), k == 43});
    end else begin
      s = pcm_of(c.sample_bits);
      expected_bytes.push_back('{s[7:0], 1'b0});
      expected_bytes.push_back('{s[15:8], 1'b1});
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall) predict_bytes(req);
      if (!req_valid || !req_stall) begin
        if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          req <= pending_cmds.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    rsp_t e;
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected byte %h last %b", $realtime, rsp.out_byte, rsp.last);
          errors++;
        end else begin
          e = expected_bytes.pop_front();
          if (rsp.out_byte !== e.out_byte || rsp.last !== e.last) begin
            $display("%0t: expected byte %h last %b, got %h last %b", $realtime,
                     e.out_byte, e.last, rsp.out_byte, rsp.last);
            errors++;
          end
        end
      end
      rsp_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic drain();
    while (pending_cmds.size() > 0 || req_valid || expected_bytes.size() > 0) begin
      @(posedge clk);
      #1;
    end
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] v);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_RATE) rate_reg = v;
    else count_reg = v[30:0];
  endtask

  function automatic logic [31:0] rand_float();
    case ($urandom_range(5))
      0: return $urandom();
      1: return {1'($urandom_range(1)), 8'd255, 23'($urandom())};
      2: return {1'($urandom_range(1)), 8'($urandom_range(100, 127)), 23'($urandom())};
      3: return {1'($urandom_range(1)), 8'($urandom_range(126, 130)), 23'($urandom())};
      default: return {1'($urandom_range(1)), 8'($urandom_range(0, 126)), 23'($urandom())};
    endcase
  endfunction

  task automatic push_sample(logic [31:0] b);
    pending_cmds.push_back('{CMD_SAMPLE, b});
  endtask

  task automatic random_phase(int n, int idle, int stall);
    send_idle_pct = idle;
    stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(15) == 0) pending_cmds.push_back('{CMD_HEADER, $urandom()});
      else push_sample(rand_float());
    end
    drain();
  endtask

  initial begin
    rate_reg = RATE_RESET;
    count_reg = COUNT_RESET;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    pending_cmds.push_back('{CMD_HEADER, 32'h0});
    push_sample(32'h0000_0000);
    push_sample(32'h8000_0000);
    push_sample(32'h3f80_0000);
    push_sample(32'hbf80_0000);
    push_sample(32'h7f80_0000);
    push_sample(32'hff80_0000);
    push_sample(32'h7fc0_0000);
    push_sample(32'hffff_ffff);
    push_sample(32'h3f7f_ffff);
    push_sample(32'hbf7f_ffff);
    push_sample(32'h0000_0001);
    push_sample(32'h3f00_0000);
    push_sample(32'hbf00_0000);
    push_sample(32'h7f7f_ffff);
    drain();
    write_reg(REG_RATE, 32'hffff_ffff);
    write_reg(REG_COUNT, 32'h7fff_ffe9);
    pending_cmds.push_back('{CMD_HEADER, 32'hffff_ffff});
    drain();
    write_reg(REG_RATE, 32'h0);
    write_reg(REG_COUNT, 32'hffff_ffff);
    pending_cmds.push_back('{CMD_HEADER, 32'h0});
    drain();
    write_reg(REG_RATE, 32'd44100);
    write_reg(REG_COUNT, 32'd0);
    random_phase(100, 0, 0);
    write_reg(REG_RATE, $urandom());
    write_reg(REG_COUNT, $urandom());
    random_phase(100, 86, 0);
    write_reg(REG_RATE, $urandom());
    write_reg(REG_COUNT, $urandom_range(2147483625));
    random_phase(100, 0, 86);
    random_phase(100, 25, 25);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end
endmodule

[sim.f]
sv/fpwbs_pkg.sv
sv/float_pcm_to_wav_byte_stream_unit.sv
sv/fpwbs_checker.sv
verif/float_pcm_to_wav_byte_stream_unit_tb.sv
